/* rtl/core/sdpa_pkg.sv */
package sdpa_pkg;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_GAIN_ALIGN,
    REG_MAX_POWER,
    REG_TICKS_PER_INCH
  } cfg_reg_t;

  localparam logic [6:0]  MAX_POWER_RST = 7'd127;
  localparam logic [15:0] TPI_RST       = 16'd8071;
  localparam logic [6:0]  MIN_POWER     = 7'd5;
  localparam logic [6:0]  CMD_MAX       = 7'd127;
  localparam logic [16:0] SHORT_MOVE    = 17'd192;
  localparam logic [19:0] TICK_MAX      = 20'hFFFFF;
  localparam logic [46:0] SUM_MAX       = {47{1'b1}};
  localparam logic [47:0] ITERM_CAP     = 48'h8000_0000_0000;

  typedef struct packed {
    logic encoder_reset;
    logic done_res;
    logic rev;
    logic left_ahead;
    logic right_ahead;
  } sdpa_flags_t;

  typedef struct packed {
    sdpa_flags_t        flags;
    logic [19:0]        cur;
    logic signed [20:0] diff;
    logic [46:0]        sum;
    logic [24:0]        egp;
    logic [19:0]        adiff;
  } sdpa_s1_t;

  typedef struct packed {
    sdpa_flags_t        flags;
    logic [44:0]        a;
    logic signed [44:0] b;
    logic [47:0]        pl;
    logic [46:0]        ph;
    logic [43:0]        al;
  } sdpa_s2_t;

  typedef struct packed {
    sdpa_flags_t        flags;
    logic signed [46:0] s;
    logic [47:0]        isat;
    logic [43:0]        al;
  } sdpa_s3_t;

  typedef struct packed {
    logic [7:0] left_power;
    logic [7:0] right_power;
    logic       encoder_reset;
    logic       done_res;
  } sdpa_res_t;

endpackage

/* rtl/core/sdpa_state.sv */
module sdpa_state import sdpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               opcode,
  input  logic signed [15:0] distance_sixteenths,
  input  logic signed [20:0] left_degrees,
  input  logic signed [20:0] right_degrees,
  input  logic [23:0]        gain_p,
  input  logic [15:0]        ticks_per_inch,
  output logic               keep,
  output sdpa_s1_t           s1_r
);

  logic        active_r, active_nxt;
  logic        reverse_r, reverse_nxt;
  logic [19:0] target_r, target_nxt;
  logic [24:0] egp_r, egp_nxt;
  logic [19:0] cur_r, cur_nxt;
  logic [46:0] sum_r, sum_nxt;
  sdpa_s1_t    s1_nxt;

  logic [16:0] dist_ext, d_mag;
  logic [32:0] tgt_prod;
  logic [19:0] tgt;
  logic [24:0] egp_new;
  logic [20:0] lneg, rneg;
  logic [19:0] lmag, rmag;
  logic [20:0] lr_sum;
  logic [19:0] avg;
  logic        reached;
  logic [19:0] cur_new;
  logic [47:0] sum_add;
  logic [46:0] sum_new;
  logic [19:0] adiff;

  always_comb begin
    dist_ext = {distance_sixteenths[15], distance_sixteenths};
    d_mag    = distance_sixteenths[15] ? (~dist_ext + 17'd1) : dist_ext;
    tgt_prod = 33'(d_mag) * 33'(ticks_per_inch);
    tgt      = tgt_prod[31:12];
    egp_new  = (d_mag < SHORT_MOVE) ? {gain_p, 1'b0} : {1'b0, gain_p};

    lneg = ~left_degrees + 21'd1;
    rneg = ~right_degrees + 21'd1;
    lmag = !left_degrees[20]  ? left_degrees[19:0]  : (lneg[20] ? TICK_MAX : lneg[19:0]);
    rmag = !right_degrees[20] ? right_degrees[19:0] : (rneg[20] ? TICK_MAX : rneg[19:0]);
    lr_sum  = {1'b0, lmag} + {1'b0, rmag};
    avg     = lr_sum[20:1];
    reached = avg >= target_r;
    cur_new = target_r - avg;
    sum_add = {1'b0, sum_r} + {28'd0, cur_r};
    sum_new = sum_add[47] ? SUM_MAX : sum_add[46:0];
    adiff   = (lmag > rmag) ? (lmag - rmag) : (rmag - lmag);

    active_nxt  = active_r;
    reverse_nxt = reverse_r;
    target_nxt  = target_r;
    egp_nxt     = egp_r;
    cur_nxt     = cur_r;
    sum_nxt     = sum_r;
    keep        = 1'b1;

    s1_nxt.flags.encoder_reset = 1'b0;
    s1_nxt.flags.done_res      = reached;
    s1_nxt.flags.rev           = reverse_r;
    s1_nxt.flags.left_ahead    = lmag > rmag;
    s1_nxt.flags.right_ahead   = rmag > lmag;
    s1_nxt.cur                 = cur_new;
    s1_nxt.diff                = $signed({1'b0, cur_new}) - $signed({1'b0, cur_r});
    s1_nxt.sum                 = sum_new;
    s1_nxt.egp                 = egp_r;
    s1_nxt.adiff               = adiff;

    if (opcode == OP_START) begin
      reverse_nxt = distance_sixteenths[15];
      target_nxt  = tgt;
      egp_nxt     = egp_new;
      cur_nxt     = '0;
      sum_nxt     = '0;
      active_nxt  = tgt != '0;
      s1_nxt.flags.encoder_reset = 1'b1;
      s1_nxt.flags.done_res      = tgt == '0;
      s1_nxt.flags.rev           = distance_sixteenths[15];
      s1_nxt.flags.left_ahead    = 1'b0;
      s1_nxt.flags.right_ahead   = 1'b0;
      s1_nxt.cur                 = '0;
      s1_nxt.diff                = '0;
      s1_nxt.sum                 = '0;
      s1_nxt.egp                 = egp_new;
      s1_nxt.adiff               = '0;
    end else if (active_r) begin
      cur_nxt = cur_new;
      sum_nxt = sum_new;
      if (reached) begin
        active_nxt = 1'b0;
      end
    end else begin
      keep = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (adv) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reverse_r <= reverse_nxt;
      target_r  <= target_nxt;
      egp_r     <= egp_nxt;
      cur_r     <= cur_nxt;
      sum_r     <= sum_nxt;
      s1_r      <= s1_nxt;
    end
  end

endmodule

/* rtl/core/sdpa_mult.sv */
module sdpa_mult import sdpa_pkg::*; (
  input  logic        clk,
  input  logic        ce2,
  input  logic        ce3,
  input  sdpa_s1_t    s1,
  input  logic [23:0] gain_i,
  input  logic [23:0] gain_d,
  input  logic [23:0] gain_align,
  output sdpa_s3_t    s3_r
);

  sdpa_s2_t    s2_r, s2_nxt;
  sdpa_s3_t    s3_nxt;
  logic [70:0] i_full;

  always_comb begin
    s2_nxt.flags = s1.flags;
    s2_nxt.a     = 45'(s1.cur) * 45'(s1.egp);
    s2_nxt.b     = 45'($signed(s1.diff)) * $signed(45'(gain_d));
    s2_nxt.pl    = 48'(s1.sum[23:0]) * 48'(gain_i);
    s2_nxt.ph    = 47'(s1.sum[46:24]) * 47'(gain_i);
    s2_nxt.al    = 44'(s1.adiff) * 44'(gain_align);
  end

  // integral term capped where it already forces the upper clamp
  always_comb begin
    i_full       = {s2_r.ph, 24'd0} + {23'd0, s2_r.pl};
    s3_nxt.flags = s2_r.flags;
    s3_nxt.isat  = (|i_full[70:47]) ? ITERM_CAP : {1'b0, i_full[46:0]};
    s3_nxt.s     = $signed({2'b00, s2_r.a}) + 47'($signed(s2_r.b));
    s3_nxt.al    = s2_r.al;
  end

  always_ff @(posedge clk) begin
    if (ce2) begin
      s2_r <= s2_nxt;
    end
    if (ce3) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

/* rtl/core/sdpa_drive.sv */
module sdpa_drive import sdpa_pkg::*; (
  input  logic       clk,
  input  logic       ce4,
  input  sdpa_s3_t   s3,
  input  logic [6:0] max_power,
  output sdpa_res_t  res
);

  sdpa_flags_t        flags_r;
  logic [22:0]        p_r, p_nxt;
  logic [43:0]        al_r;
  logic signed [48:0] p_raw;
  logic [22:0]        max_q, min_q;

  always_comb begin
    max_q = {max_power, 16'd0};
    min_q = {MIN_POWER, 16'd0};
    p_raw = 49'(s3.s) + $signed({1'b0, s3.isat});
    if (p_raw > $signed({26'd0, max_q})) begin
      p_nxt = max_q;
    end else if (p_raw < $signed({26'd0, min_q})) begin
      p_nxt = min_q;
    end else begin
      p_nxt = p_raw[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce4) begin
      flags_r <= s3.flags;
      p_r     <= p_nxt;
      al_r    <= s3.al;
    end
  end

  function automatic logic [7:0] side_cmd(input logic [22:0] p, input logic [43:0] al,
                                          input logic lose, input logic rev);
    logic        neg;
    logic [43:0] mag;
    logic [6:0]  cmd;
    logic [7:0]  cmd8;
    neg = 1'b0;
    mag = 44'(p);
    if (lose) begin
      neg = al > 44'(p);
      mag = neg ? (al - 44'(p)) : (44'(p) - al);
    end
    cmd  = (|mag[43:23]) ? CMD_MAX : mag[22:16];
    cmd8 = {1'b0, cmd};
    return (neg ^ rev) ? (~cmd8 + 8'd1) : cmd8;
  endfunction

  always_comb begin
    res.encoder_reset = flags_r.encoder_reset;
    res.done_res      = flags_r.done_res;
    if (flags_r.done_res) begin
      res.left_power  = '0;
      res.right_power = '0;
    end else begin
      res.left_power  = side_cmd(p_r, al_r, flags_r.left_ahead, flags_r.rev);
      res.right_power = side_cmd(p_r, al_r, flags_r.right_ahead, flags_r.rev);
    end
  end

endmodule

/* rtl/core/straight_drive_pid_align_top.sv */
// channel | beat fields (low bit up)                                 | dir
// in_     | tuser: opcode; tdata: distance_sixteenths, left_degrees,  | in
//         |        right_degrees, zero pad to 64                      |
// out_    | tdata: left_power, right_power; tuser: encoder_reset,     | out
//         |        done_res                                           |
// cfg_    | wen, addr (register index), wdata (24 bit)                | in
// One beat per cycle while no stage holds; a result passes through the input register,
// state update, multipliers, sum, clamp and output register.
// Samples taken while no move is active are dropped with no result.
// Synchronous active-low reset loads register defaults and ends any move.
// Each stage holds only when it is full and the stage after it holds; empty
// stages keep taking beats while out_tready is low.
module straight_drive_pid_align_top import sdpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // distance_sixteenths, left_degrees, right_degrees, pad
  input  logic [0:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // left_power, right_power
  output logic [1:0]  out_tuser,  // encoder_reset, done_res
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  logic [23:0] gain_p_r, gain_i_r, gain_d_r, gain_align_r;
  logic [6:0]  max_power_r;
  logic [15:0] tpi_r;

  logic               v0_r, v1_r, v2_r, v3_r, v4_r, out_v_r;
  logic               ce0, ce1, ce2, ce3, ce4, ce_out;
  logic               op_r;
  logic signed [15:0] dist_r;
  logic signed [20:0] left_r, right_r;
  logic               keep;
  sdpa_s1_t           s1;
  sdpa_s3_t           s3;
  sdpa_res_t          res, res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      gain_align_r <= '0;
      max_power_r  <= MAX_POWER_RST;
      tpi_r        <= TPI_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GAIN_P:         gain_p_r     <= cfg_wdata;
        REG_GAIN_I:         gain_i_r     <= cfg_wdata;
        REG_GAIN_D:         gain_d_r     <= cfg_wdata;
        REG_GAIN_ALIGN:     gain_align_r <= cfg_wdata;
        REG_MAX_POWER:      max_power_r  <= cfg_wdata[6:0];
        REG_TICKS_PER_INCH: tpi_r        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign ce_out    = !out_v_r || out_tready;
  assign ce4       = !v4_r || ce_out;
  assign ce3       = !v3_r || ce4;
  assign ce2       = !v2_r || ce3;
  assign ce1       = !v1_r || ce2;
  assign ce0       = !v0_r || ce1;
  assign in_tready = ce0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ce0)    v0_r    <= in_tvalid;
      if (ce1)    v1_r    <= v0_r && keep;
      if (ce2)    v2_r    <= v1_r;
      if (ce3)    v3_r    <= v2_r;
      if (ce4)    v4_r    <= v3_r;
      if (ce_out) out_v_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce0) begin
      op_r    <= in_tuser[0];
      dist_r  <= in_tdata[15:0];
      left_r  <= in_tdata[36:16];
      right_r <= in_tdata[57:37];
    end
    if (ce_out) begin
      res_r <= res;
    end
  end

  sdpa_state u_state (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (ce1 && v0_r),
    .opcode              (op_r),
    .distance_sixteenths (dist_r),
    .left_degrees        (left_r),
    .right_degrees       (right_r),
    .gain_p              (gain_p_r),
    .ticks_per_inch      (tpi_r),
    .keep                (keep),
    .s1_r                (s1)
  );

  sdpa_mult u_mult (
    .clk        (clk),
    .ce2        (ce2),
    .ce3        (ce3),
    .s1         (s1),
    .gain_i     (gain_i_r),
    .gain_d     (gain_d_r),
    .gain_align (gain_align_r),
    .s3_r       (s3)
  );

  sdpa_drive u_drive (
    .clk       (clk),
    .ce4       (ce4),
    .s3        (s3),
    .max_power (max_power_r),
    .res       (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {res_r.right_power, res_r.left_power};
  assign out_tuser  = {res_r.done_res, res_r.encoder_reset};

endmodule

/* verif/straight_drive_pid_align_top_tb.sv */
`timescale 1ns / 100ps

module straight_drive_pid_align_top_tb import sdpa_pkg::*;;

  localparam longint ITERM_SAT = longint'(1) << 50;
  localparam longint ACC_MAX   = (longint'(1) << 47) - 1;
  localparam longint MAG_MAX   = 1048575;

  typedef struct packed {
    logic        op;
    logic [15:0] span;
    logic [20:0] lft;
    logic [20:0] rgt;
    logic        typed;
    sdpa_res_t   res;
  } row_t;

  localparam sdpa_res_t NO_CMD    = '0;
  localparam sdpa_res_t NULL_MOVE = '{8'd0, 8'd0, 1'b1, 1'b1};
  localparam sdpa_res_t FWD_MIN   = '{8'd5, 8'd5, 1'b1, 1'b0};
  localparam sdpa_res_t REV_MIN   = '{8'hFB, 8'hFB, 1'b1, 1'b0};
  localparam sdpa_res_t HOLD_MIN  = '{8'd5, 8'd5, 1'b0, 1'b0};
  localparam sdpa_res_t ARRIVED   = '{8'd0, 8'd0, 1'b0, 1'b1};

  // reset settings: all gains zero, max power 127, 8071 ticks per inch
  localparam int NDIR = 20;
  localparam row_t DIRECTED [NDIR] = '{
    '{OP_SAMPLE, 16'h0000, 21'h000000, 21'h000000, 1'b0, NO_CMD},
    '{OP_START,  16'h0000, 21'h000000, 21'h000000, 1'b1, NULL_MOVE},
    '{OP_SAMPLE, 16'h0000, 21'h0FFFFF, 21'h100000, 1'b0, NO_CMD},
    '{OP_START,  16'h7FFF, 21'h000000, 21'h000000, 1'b1, FWD_MIN},
    '{OP_SAMPLE, 16'h0000, 21'h000000, 21'h000000, 1'b1, HOLD_MIN},
    '{OP_SAMPLE, 16'h0000, 21'd1000,   21'h1FF448, 1'b0, NO_CMD},
    '{OP_SAMPLE, 16'h0000, 21'h100000, 21'h0FFFFF, 1'b1, ARRIVED},
    '{OP_START,  16'h8000, 21'h000000, 21'h000000, 1'b1, REV_MIN},
    '{OP_SAMPLE, 16'h0000, 21'd12345,  21'd678,    1'b0, NO_CMD},
    '{OP_START,  16'd191,  21'h000000, 21'h000000, 1'b1, FWD_MIN},
    '{OP_SAMPLE, 16'h0000, 21'd100,    21'd200,    1'b0, NO_CMD},
    '{OP_SAMPLE, 16'h0000, 21'h0FFFFF, 21'h0FFFFF, 1'b1, ARRIVED},
    '{OP_START,  16'd1,    21'h000000, 21'h000000, 1'b1, FWD_MIN},
    '{OP_SAMPLE, 16'h0000, 21'd1,      21'd0,      1'b0, NO_CMD},
    '{OP_SAMPLE, 16'h0000, 21'd2,      21'd1,      1'b1, ARRIVED},
    '{OP_START,  16'hFFFF, 21'h000000, 21'h000000, 1'b1, REV_MIN},
    '{OP_SAMPLE, 16'h0000, 21'h1FFFFF, 21'h1FFFFE, 1'b1, ARRIVED},
    '{OP_START,  16'd192,  21'h000000, 21'h000000, 1'b1, FWD_MIN},
    '{OP_START,  16'hFF3F, 21'h000000, 21'h000000, 1'b1, REV_MIN},
    '{OP_SAMPLE, 16'h0000, 21'h0AAAAA, 21'h155555, 1'b1, ARRIVED}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  straight_drive_pid_align_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int errors = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  sdpa_res_t pending_cmds [$];

  // register copies
  logic [23:0] kp = '0, ki = '0, kd = '0, ka = '0;
  logic [6:0]  pmax = MAX_POWER_RST;
  logic [15:0] tpi = TPI_RST;

  // controller state
  bit          mv_active = 1'b0;
  bit          mv_rev = 1'b0;
  logic [19:0] mv_target = '0;
  logic [24:0] mv_kp = '0;
  longint      lt = 0, rt = 0, err_now = 0, err_prev = 0, err_acc = 0;

  function automatic longint to_power(longint q);
    longint i;
    i = (q >= 0) ? (q >>> 16) : -((-q) >>> 16);
    if (i > 127) i = 127;
    if (i < -127) i = -127;
    return i;
  endfunction

  function automatic longint tick_mag(logic signed [20:0] v);
    longint x;
    x = longint'(v);
    if (x < 0) x = -x;
    return (x > MAG_MAX) ? MAG_MAX : x;
  endfunction

  function automatic sdpa_res_t motor_cmd();
    longint p, iterm, lim, skew, l, r;
    sdpa_res_t c;
    c = '0;
    p = err_now * longint'(mv_kp) + (err_now - err_prev) * longint'(kd);
    iterm = 0;
    if (ki != 0) begin
      lim = ITERM_SAT / longint'(ki);
      if (err_acc > lim) iterm = ITERM_SAT;
      else if (err_acc < -lim) iterm = -ITERM_SAT;
      else iterm = err_acc * longint'(ki);
    end
    p += iterm;
    if (p > (longint'(pmax) << 16)) p = longint'(pmax) << 16;
    else if (p < (longint'(MIN_POWER) << 16)) p = longint'(MIN_POWER) << 16;
    skew = ((lt > rt) ? lt - rt : rt - lt) * longint'(ka);
    l = (lt > rt) ? p - skew : p;
    r = (rt > lt) ? p - skew : p;
    if (mv_rev) begin
      l = -l;
      r = -r;
    end
    c.left_power = 8'(to_power(l));
    c.right_power = 8'(to_power(r));
    return c;
  endfunction

  task automatic advance_controller(input logic op, input logic [15:0] span,
                                    input logic [20:0] lft, input logic [20:0] rgt,
                                    output bit has, output sdpa_res_t res);
    longint d, avg;
    has = 1'b1;
    res = '0;
    if (op == OP_START) begin
      d = longint'($signed(span));
      mv_rev = (d < 0);
      if (d < 0) d = -d;
      mv_target = 20'((d * longint'(tpi)) >> 12);
      mv_kp = (d < longint'(SHORT_MOVE)) ? {kp, 1'b0} : {1'b0, kp};
      lt = 0; rt = 0; err_now = 0; err_prev = 0; err_acc = 0;
      if (mv_target == 0) begin
        mv_active = 1'b0;
        res.done_res = 1'b1;
      end else begin
        mv_active = 1'b1;
        res = motor_cmd();
      end
      res.encoder_reset = 1'b1;
    end else if (!mv_active) begin
      has = 1'b0;
    end else begin
      lt = tick_mag(lft);
      rt = tick_mag(rgt);
      avg = (lt + rt) / 2;
      err_prev = err_now;
      err_acc += err_prev;
      if (err_acc > ACC_MAX) err_acc = ACC_MAX;
      if (err_acc < -ACC_MAX - 1) err_acc = -ACC_MAX - 1;
      err_now = longint'(mv_target) - avg;
      if (avg >= longint'(mv_target)) begin
        mv_active = 1'b0;
        res.done_res = 1'b1;
      end else begin
        res = motor_cmd();
      end
    end
  endtask

  task automatic send_beat(input logic op, input logic [15:0] span, input logic [20:0] lft,
                           input logic [20:0] rgt, input logic typed, input sdpa_res_t want);
    bit has;
    sdpa_res_t res;
    while ($urandom_range(99) < snd_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, rgt, lft, span};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_controller(op, span, lft, rgt, has, res);
    if (has) pending_cmds.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:         kp = val;
      REG_GAIN_I:         ki = val;
      REG_GAIN_D:         kd = val;
      REG_GAIN_ALIGN:     ka = val;
      REG_MAX_POWER:      pmax = val[6:0];
      REG_TICKS_PER_INCH: tpi = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [23:0] small_gain(int bits);
    return 24'($urandom_range(0, 1 << bits));
  endfunction

  // gains, max power, ticks per inch and idle mix for each phase
  task automatic apply_settings(int ph);
    logic [23:0] gp, gi, gd, ga, mp, tp;
    gp = small_gain(13);
    gi = small_gain(8);
    gd = small_gain(14);
    ga = small_gain(16);
    mp = 24'd127;
    tp = 24'(TPI_RST);
    snd_pct = 0;
    rcv_pct = 0;
    case (ph)
      1: begin
        mp = 24'($urandom_range(5, 127));
        tp = 24'($urandom_range(2000, 20000));
        snd_pct = 67;
      end
      2: begin
        gp = 24'hFFFFFF; gi = 24'hFFFFFF; gd = 24'hFFFFFF; ga = 24'hFFFFFF;
        tp = 24'h00FFFF;
        rcv_pct = 67;
      end
      3: begin
        mp = 24'd4;
        snd_pct = 20;
        rcv_pct = 20;
      end
      4: begin
        gp = '0; gi = '0; gd = '0; ga = '0;
        mp = '0;
        tp = '0;
        snd_pct = 67;
      end
      5: begin
        gp = 24'($urandom); gi = 24'($urandom); gd = 24'($urandom); ga = 24'($urandom);
        mp = 24'($urandom);
        tp = 24'($urandom);
      end
      6: begin
        tp = 24'h00FFFF;
        rcv_pct = 67;
      end
      7: begin
        gi = small_gain(12);
        mp = 24'd60;
        snd_pct = 20;
        rcv_pct = 20;
      end
      default: ;
    endcase
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_GAIN_ALIGN, ga);
    write_reg(REG_MAX_POWER, mp);
    write_reg(REG_TICKS_PER_INCH, tp);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [15:0] pick_distance();
    int s, mag;
    s = $urandom_range(15);
    if (s < 8) mag = $urandom_range(1, 400);
    else if (s < 12) mag = $urandom_range(1, 4000);
    else if (s < 14) return 16'($urandom);
    else begin
      case ($urandom_range(5))
        0: mag = 0;
        1: mag = 191;
        2: mag = 192;
        3: mag = 193;
        4: return 16'h8000;
        default: return 16'h7FFF;
      endcase
    end
    return $urandom_range(1) ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic logic [20:0] to_degrees(longint mag);
    if (mag > MAG_MAX) mag = MAG_MAX;
    if ($urandom_range(7) == 0) begin
      return (mag == MAG_MAX && $urandom_range(1)) ? 21'h100000 : 21'(-mag);
    end
    return 21'(mag);
  endfunction

  // moves: a start followed by samples that close in on the target, mixed with occasional random beats
  task automatic run_moves(int n);
    int sent, nsamp, spread, k;
    logic op;
    bit slow;
    longint base, jit, l, r, tmp;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 8) begin
        op = 1'($urandom_range(1));
        if (op == OP_START || mv_active) sent++;
        send_beat(op, 16'($urandom), 21'($urandom), 21'($urandom), 1'b0, NO_CMD);
      end else begin
        send_beat(OP_START, pick_distance(), '0, '0, 1'b0, NO_CMD);
        sent++;
        slow = ($urandom_range(15) == 0);
        nsamp = slow ? $urandom_range(100, 200) : $urandom_range(1, 12);
        case ($urandom_range(3))
          0: spread = 0;
          1: spread = int'(mv_target >> 3);
          default: spread = $urandom_range(0, 64);
        endcase
        for (k = 1; k <= nsamp && sent < n && mv_active; k++) begin
          if (k == nsamp) base = longint'(mv_target) + $urandom_range(0, 3) - 1;
          else if (slow) base = longint'(mv_target) * k / (2 * nsamp);
          else base = longint'(mv_target) * k / nsamp;
          jit = $urandom_range(0, spread);
          l = base + jit;
          r = base - jit;
          if (r < 0) r = 0;
          if ($urandom_range(1)) begin
            tmp = l; l = r; r = tmp;
          end
          send_beat(OP_SAMPLE, 16'($urandom), to_degrees(l), to_degrees(r), 1'b0, NO_CMD);
          sent++;
        end
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
    end
  endfunction

  always @(posedge clk) begin
    sdpa_res_t want;
    out_tready <= ($urandom_range(99) >= rcv_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        errors++;
        $error("result beat with no command pending: tdata %h tuser %b", out_tdata, out_tuser);
      end else begin
        want = pending_cmds.pop_front();
        check_field("left_power", want.left_power, out_tdata[7:0]);
        check_field("right_power", want.right_power, out_tdata[15:8]);
        check_field("encoder_reset", {7'd0, want.encoder_reset}, {7'd0, out_tuser[0]});
        check_field("done_res", {7'd0, want.done_res}, {7'd0, out_tuser[1]});
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NDIR; i++) begin
      send_beat(DIRECTED[i].op, DIRECTED[i].span, DIRECTED[i].lft, DIRECTED[i].rgt,
                DIRECTED[i].typed, DIRECTED[i].res);
    end
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      apply_settings(ph);
      run_moves((ph == 4) ? 20 : 50);
      drain();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
